[hdl/b32b64_pkg.sv]
// shared types and constants for the base32 to base64 transcoder
`default_nettype none
package b32b64_pkg;

	localparam logic [7:0] CHAR_PAD = 8'h3d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	typedef struct packed {
		logic [7:0] ch;
		logic has_ch;
		logic [1:0] pads;
		logic term;
		logic bad;
	} job_t;

endpackage
`default_nettype wire

[hdl/base32_to_base64_transcoder.sv]
// top level of the base32 to base64 transcoder
//
//   channel   ports                          handshake
//   input     symbol                         push / full
//   result    out_char, last, bad_symbol     pop / empty
//
// one symbol is accepted per cycle while full is low; any job it yields passes the
// job queue and the output register; a terminator expands into up to four words,
// one per cycle from the back end unless pop stalls it, so the two-entry queue can
// fill; full follows the job queue only; the back end stalls on pop alone
// arst_n clears the bit buffer, counters, queue pointers and output valid flag
`default_nettype none
module base32_to_base64_transcoder (
	input wire clk,
	input wire arst_n,
	input wire [7:0] symbol,
	input wire push,
	output logic full,
	output logic empty,
	input wire pop,
	output logic [7:0] out_char,
	output logic last,
	output logic bad_symbol
);
	import b32b64_pkg::*;

	job_t new_job;
	logic new_job_valid;
	logic q_full;
	job_t head_job;
	logic head_valid;
	logic head_take;

	b32b64_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.symbol(symbol),
		.push(push),
		.full(full),
		.job(new_job),
		.job_valid(new_job_valid),
		.job_full(q_full)
	);

	b32b64_job_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push && new_job_valid),
		.wr_job(new_job),
		.full(q_full),
		.rd_job(head_job),
		.rd_valid(head_valid),
		.rd_en(head_take)
	);

	b32b64_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head_job),
		.head_valid(head_valid),
		.take(head_take),
		.empty(empty),
		.pop(pop),
		.out_char(out_char),
		.last(last),
		.bad_symbol(bad_symbol)
	);

endmodule
`default_nettype wire

[hdl/b32b64_front.sv]
// front end: classifies symbols, repacks bits and issues output jobs
`default_nettype none
module b32b64_front (
	input wire clk,
	input wire arst_n,
	input wire [7:0] symbol,
	input wire push,
	output logic full,
	output b32b64_pkg::job_t job,
	output logic job_valid,
	input wire job_full
);
	import b32b64_pkg::*;

	logic [9:0] bit_buffer_q;
	logic [2:0] bits_held_q;
	logic [1:0] emitted_mod_four_q;

	logic is_term;
	logic is_b32;
	logic [4:0] val;
	logic [15:0] flush_sh;
	logic [9:0] nb;
	logic [3:0] nh;
	logic [3:0] nh2;
	logic [9:0] keep_mask;
	logic [5:0] dig;
	logic [1:0] mod1;
	logic [9:0] buf_d;
	logic [2:0] held_d;
	logic [1:0] mod_d;
	logic accept;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] r;
		if (v <= 6'd25) begin
			r = {2'b00, v} + 8'd65;
		end else if (v <= 6'd51) begin
			r = {2'b00, v} + 8'd71;
		end else if (v <= 6'd61) begin
			r = {2'b00, v} - 8'd4;
		end else if (v == 6'd62) begin
			r = 8'h2b;
		end else begin
			r = 8'h2f;
		end
		return r;
	endfunction

	assign full = job_full;
	assign accept = push && !job_full;

	always_comb begin
		logic [7:0] t;
		is_term = (symbol == CHAR_PAD) || (symbol == CHAR_LF) || (symbol == CHAR_NUL);
		is_b32 = 1'b0;
		val = 5'd0;
		t = 8'd0;
		if (symbol inside {[8'h41:8'h5a]}) begin
			is_b32 = 1'b1;
			t = symbol - 8'd65;
			val = t[4:0];
		end else if (symbol inside {[8'h32:8'h37]}) begin
			is_b32 = 1'b1;
			t = symbol - 8'd24;
			val = t[4:0];
		end
	end

	always_comb begin
		flush_sh = {6'd0, bit_buffer_q} << (3'd6 - bits_held_q);
		nb = {bit_buffer_q[4:0], val};
		nh = {1'b0, bits_held_q} + 4'd5;
		nh2 = nh - 4'd6;
		keep_mask = (10'd1 << nh2) - 10'd1;
		mod1 = emitted_mod_four_q + {1'b0, bits_held_q != 3'd0};

		job = '0;
		job_valid = 1'b0;
		buf_d = bit_buffer_q;
		held_d = bits_held_q;
		mod_d = emitted_mod_four_q;
		dig = 6'd0;

		if (is_term) begin
			job.ch = b64_char(flush_sh[5:0]);
			job.has_ch = bits_held_q != 3'd0;
			job.pads = 2'd0 - mod1;
			job.term = 1'b1;
			job_valid = job.has_ch || (job.pads != 2'd0);
			buf_d = 10'd0;
			held_d = 3'd0;
			mod_d = 2'd0;
		end else if (!is_b32) begin
			job.has_ch = 1'b1;
			job.bad = 1'b1;
			job_valid = 1'b1;
		end else if (nh >= 4'd6) begin
			dig = 6'(nb >> (nh - 4'd6));
			job.ch = b64_char(dig);
			job.has_ch = 1'b1;
			job_valid = 1'b1;
			buf_d = nb & keep_mask;
			held_d = nh2[2:0];
			mod_d = emitted_mod_four_q + 2'd1;
		end else begin
			buf_d = nb;
			held_d = nh[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_buffer_q <= 10'd0;
			bits_held_q <= 3'd0;
			emitted_mod_four_q <= 2'd0;
		end else if (accept) begin
			bit_buffer_q <= buf_d;
			bits_held_q <= held_d;
			emitted_mod_four_q <= mod_d;
		end
	end

endmodule
`default_nettype wire

[hdl/b32b64_job_fifo.sv]
// two-entry job queue between front end and back end
`default_nettype none
module b32b64_job_fifo (
	input wire clk,
	input wire arst_n,
	input wire wr_en,
	input wire b32b64_pkg::job_t wr_job,
	output logic full,
	output b32b64_pkg::job_t rd_job,
	output logic rd_valid,
	input wire rd_en
);
	import b32b64_pkg::*;

	job_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = count_q == 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_job = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

endmodule
`default_nettype wire

[hdl/b32b64_back.sv]
// back end: expands jobs into output words with padding
`default_nettype none
module b32b64_back (
	input wire clk,
	input wire arst_n,
	input wire b32b64_pkg::job_t head,
	input wire head_valid,
	output logic take,
	output logic empty,
	input wire pop,
	output logic [7:0] out_char,
	output logic last,
	output logic bad_symbol
);
	import b32b64_pkg::*;

	logic [1:0] idx_q;
	logic out_valid_q;
	logic [2:0] total;
	logic final_word;
	logic ld;
	logic char_phase;

	assign total = {2'b00, head.has_ch} + {1'b0, head.pads};
	assign final_word = ({1'b0, idx_q} == (total - 3'd1));
	assign ld = head_valid && (!out_valid_q || pop);
	assign take = ld && final_word;
	assign char_phase = head.has_ch && (idx_q == 2'd0);
	assign empty = !out_valid_q;

	always_ff @(posedge clk) begin
		if (ld) begin
			out_char <= char_phase ? head.ch : CHAR_PAD;
			last <= head.term && final_word;
			bad_symbol <= head.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld) begin
				idx_q <= final_word ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
